>>> design/pol_pkg.sv
// ----------------------------------------------------------------------------
// pol_pkg: shared definitions for the positional ordered list
// Command and status codes, the cell operation type and the control bundle
// broadcast from the sequencer to every storage cell.
// ----------------------------------------------------------------------------
package pol_pkg;

  // Default number of storage cells
  localparam int unsigned CapacityDefault = 32;

  // Field widths fixed by the stream format
  localparam int unsigned CmdW   = 2;
  localparam int unsigned PosW   = 6;
  localparam int unsigned ValW   = 8;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CountW = 6;

  // Compare width for positions and lengths (holds 0 to 64 and any 6-bit position)
  localparam int unsigned CmpW = 7;

  // Command codes
  localparam logic [CmdW-1:0] CMD_INSERT = 2'd0;
  localparam logic [CmdW-1:0] CMD_DELETE = 2'd1;
  localparam logic [CmdW-1:0] CMD_READ   = 2'd2;

  // Status codes
  localparam logic [StatW-1:0] ST_OK     = 2'd0;
  localparam logic [StatW-1:0] ST_BADPOS = 2'd1;
  localparam logic [StatW-1:0] ST_EMPTY  = 2'd2;
  localparam logic [StatW-1:0] ST_FULL   = 2'd3;

  // What every cell does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_op_e;

  // Control broadcast to the row of cells
  typedef struct packed {
    cell_op_e          op;
    logic [CmpW-1:0]   pos;
    logic [CmpW-1:0]   len;
    logic [ValW-1:0]   value;
  } cell_ctrl_t;

endpackage

>>> design/pol_cell.sv
// ----------------------------------------------------------------------------
// pol_cell: one storage cell of the list
// Holds one byte and, per the broadcast operation, keeps it, loads the new
// value, or takes the byte of its left or right neighbor or the list head.
// ----------------------------------------------------------------------------
module pol_cell
  import pol_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  logic            clk_i,
  input  cell_ctrl_t      ctrl_i,
  input  logic [ValW-1:0] left_i,   // byte of cell IDX-1
  input  logic [ValW-1:0] right_i,  // byte of cell IDX+1
  input  logic [ValW-1:0] head_i,   // byte of cell 0
  output logic [ValW-1:0] data_o
);

  localparam logic [CmpW-1:0] MyIdx = CmpW'(IDX);

  logic [ValW-1:0] data_q, data_d;

  // Next byte of this cell
  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      CELL_INSERT: begin
        if (MyIdx == ctrl_i.pos) begin
          data_d = ctrl_i.value;
        end else if (MyIdx > ctrl_i.pos) begin
          data_d = left_i;
        end
      end
      CELL_DELETE: begin
        if (MyIdx >= ctrl_i.pos) begin
          data_d = right_i;
        end
      end
      CELL_ROTATE: begin
        // tail of the list takes the head, the rest move down
        if (MyIdx == ctrl_i.len - CmpW'(1)) begin
          data_d = head_i;
        end else begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

>>> design/positional_ordered_list.sv
// ----------------------------------------------------------------------------
// positional_ordered_list: ordered byte list with insert/delete at an index
// A row of CAPACITY cells holds the list; the sequencer broadcasts one
// operation per cycle and every cell updates from its neighbors.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream carries commands: insert a value at a position, delete at
//    a position, or read out the whole list.
//  - Master stream carries results: status, element, count, with tlast on
//    the final result of each command.
//  - Insert, delete, unused command and read-out of an empty list give one
//    result, registered in the cycle after the transaction; the next command is
//    taken in the following cycle, so one command per cycle when the
//    receiver keeps up.
//  - A read-out of N elements gives N results, one per cycle while the
//    receiver keeps up, by rotating the cell row once per element; the list
//    is back in place after the last one. No command is taken during the
//    read-out.
//  - Reset empties the list (length zero); the cell contents are left as is.
//  - When the receiver stalls, the result register holds and no new command
//    or read-out step is taken until it is free.
// ----------------------------------------------------------------------------
module positional_ordered_list
  import pol_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command, position, value: [1:0] command, [7:2] position, [15:8] value
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,
  // result: [1:0] status, [9:2] element, [15:10] count
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o
);

  localparam int unsigned LenW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RD   = 1'b1;

  // Input fields
  logic [CmdW-1:0] cmd;
  logic [PosW-1:0] position;
  logic [ValW-1:0] value;
  assign cmd      = s_axis_tdata_i[1:0];
  assign position = s_axis_tdata_i[7:2];
  assign value    = s_axis_tdata_i[15:8];

  logic            state_q, state_d;
  logic [LenW-1:0] len_q, len_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;

  logic              m_valid_q, m_valid_d;
  logic [StatW-1:0]  m_status_q, m_status_d;
  logic [ValW-1:0]   m_elem_q, m_elem_d;
  logic [CountW-1:0] m_count_q, m_count_d;
  logic              m_last_q, m_last_d;

  cell_ctrl_t      ctrl;
  logic [ValW-1:0] cell_data [CAPACITY];

  logic            out_free, in_acc, rd_last;
  logic [CmpW-1:0] pos_ext, len_ext;

  assign pos_ext  = CmpW'(position);
  assign len_ext  = CmpW'(len_q);
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign rd_last  = (CmpW'(rd_idx_q) == len_ext - CmpW'(1));

  // Sequencer: command decode, read-out stepping, result register load
  always_comb begin
    state_d    = state_q;
    len_d      = len_q;
    rd_idx_d   = rd_idx_q;
    m_valid_d  = m_valid_q && !m_axis_tready_i;
    m_status_d = m_status_q;
    m_elem_d   = m_elem_q;
    m_count_d  = m_count_q;
    m_last_d   = m_last_q;
    ctrl.op    = CELL_HOLD;
    ctrl.pos   = pos_ext;
    ctrl.len   = len_ext;
    ctrl.value = value;

    if (state_q == ST_IDLE) begin
      if (in_acc) begin
        m_valid_d  = 1'b1;
        m_status_d = ST_OK;
        m_elem_d   = '0;
        m_last_d   = 1'b1;
        case (cmd)
          CMD_INSERT: begin
            if (pos_ext > len_ext) begin
              m_status_d = ST_BADPOS;
            end else if (len_ext == CmpW'(CAPACITY)) begin
              m_status_d = ST_FULL;
            end else begin
              ctrl.op = CELL_INSERT;
              len_d   = len_q + LenW'(1);
            end
          end
          CMD_DELETE: begin
            if (len_q == '0) begin
              m_status_d = ST_EMPTY;
            end else if (pos_ext >= len_ext) begin
              m_status_d = ST_BADPOS;
            end else begin
              ctrl.op = CELL_DELETE;
              len_d   = len_q - LenW'(1);
            end
          end
          CMD_READ: begin
            if (len_q == '0) begin
              m_status_d = ST_EMPTY;
            end else begin
              // results come from the read-out steps
              m_valid_d = 1'b0;
              state_d   = ST_RD;
              rd_idx_d  = '0;
            end
          end
          default: m_status_d = ST_OK;
        endcase
        m_count_d = CountW'(len_d);
      end
    end else begin
      // one element per step: present the head and rotate the row
      if (out_free) begin
        ctrl.op    = CELL_ROTATE;
        m_valid_d  = 1'b1;
        m_status_d = ST_OK;
        m_elem_d   = cell_data[0];
        m_count_d  = CountW'(len_q);
        m_last_d   = rd_last;
        rd_idx_d   = rd_idx_q + IdxW'(1);
        if (rd_last) begin
          state_d = ST_IDLE;
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      len_q     <= '0;
      rd_idx_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      len_q     <= len_d;
      rd_idx_q  <= rd_idx_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    m_status_q <= m_status_d;
    m_elem_q   <= m_elem_d;
    m_count_q  <= m_count_d;
    m_last_q   <= m_last_d;
  end

  // Row of cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ValW-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = ctrl.value;
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = cell_data[g];
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end
    pol_cell #(
      .IDX(g)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .left_i (left),
      .right_i(right),
      .head_i (cell_data[0]),
      .data_o (cell_data[g])
    );
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {m_count_q, m_elem_q, m_status_q};
  assign m_axis_tlast_o  = m_last_q;

endmodule

>>> design/pol_checker.sv
// ----------------------------------------------------------------------------
// pol_checker: port-level checks for the positional ordered list
// Watches the command and result streams and flags sequencing slips.
// ----------------------------------------------------------------------------
module pol_checker
  import pol_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [15:0] s_axis_tdata_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  // A command other than read shows its result, marked last, in the next cycle
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && (s_axis_tdata_i[1:0] != CMD_READ))
    |=> (m_axis_tvalid_o && m_axis_tlast_o))
    else $error("single-result command did not give a last result");

  // No command is taken while a result is stalled
  a_no_accept_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("command taken while result stalled");

  // Failed operations carry a zero element
  a_err_elem_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tdata_o[1:0] != ST_OK)) |-> (m_axis_tdata_o[9:2] == '0))
    else $error("error result with nonzero element");

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i)
    |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)))
    else $error("stalled result changed");

endmodule

bind positional_ordered_list pol_checker u_pol_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .s_axis_tdata_i (s_axis_tdata_i),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tlast_o (m_axis_tlast_o)
);
